// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lkpt_pkg.sv -----
package lkpt_pkg;

   localparam int STAMP_W   = 32;
   localparam int LADDR_W   = 18;
   localparam int PHYS_W    = 16;
   localparam int OUTCOME_W = 2;
   localparam int VICTIM_W  = 6;

   localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFE;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic resolve;
      logic scan_start;
      logic scan_step;
      logic evict;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic hit;
      logic has_free;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/lkpt_ctrl.sv -----
`include "assert_macros.svh"

module lkpt_ctrl
   import lkpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_LOOK   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_EVICT  = 7'b0100000,
      ST_UPDATE = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Clear tables, then sequence items: lookup, optional victim scan, update
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.resolve = 1'b1;
            if (status.hit || status.has_free) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_to_read, clock, reset, req_valid && req_ready, state_ff == ST_READ, "accepted item did not start lookup")
   `ASSERT_IMPLIES(a_commit_slot_free, clock, reset, cmd.commit, status.out_free, "commit while result slot busy")

endmodule

// ----- rtl/lkpt_dpath.sv -----
`include "assert_macros.svh"

module lkpt_dpath
   import lkpt_pkg::*;
#(
   parameter int PAGES       = 64,
   parameter int FRAMES      = 16,
   parameter int OFFSET_BITS = 12,
   parameter int HISTORY_K   = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [LADDR_W-1:0]   req_logical_address,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PHYS_W-1:0]    rsp_physical_address,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [VICTIM_W-1:0]  rsp_victim_page
);

   localparam int ADDR_W    = $clog2(PAGES);
   localparam int PAGE_BITS = $clog2(PAGES + 1) - 1;
   localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FILL_W    = $clog2(FRAMES + 1);
   localparam int CNT_W     = $clog2(HISTORY_K + 1);
   localparam int STAMPS_W  = HISTORY_K * STAMP_W;
   localparam int HIST_W    = CNT_W + STAMPS_W;
   localparam int MAP_W     = 1 + FRAME_W;
   localparam int OWN_W     = ADDR_W + STAMP_W;

   // Item registers
   logic [LADDR_W-1:0]   addr_ff, addr_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [ADDR_W-1:0]    victim_ff, victim_in;
   // Control registers
   logic [ADDR_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // Victim search registers
   logic [FRAME_W-1:0]   best_frame_ff, best_frame_in;
   logic [STAMP_W-1:0]   best_time_ff, best_time_in;
   logic [ADDR_W-1:0]    best_page_ff, best_page_in;
   // Result registers
   logic [PHYS_W-1:0]    rsp_phys_ff, rsp_phys_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [VICTIM_W-1:0]  rsp_victim_ff, rsp_victim_in;

   // Memories and their registered read data
   logic [MAP_W-1:0]  map_mem [PAGES];
   logic [HIST_W-1:0] hist_mem [PAGES];
   logic [OWN_W-1:0]  own_mem [FRAMES];
   logic [MAP_W-1:0]  map_rd_ff;
   logic [HIST_W-1:0] hist_rd_ff;
   logic [OWN_W-1:0]  own_rd_ff;

   logic [31:0]          shifted;
   logic [ADDR_W-1:0]    page_w;
   logic                 map_we;
   logic [ADDR_W-1:0]    map_wa;
   logic [MAP_W-1:0]     map_wd;
   logic                 hist_we;
   logic [ADDR_W-1:0]    hist_wa;
   logic [HIST_W-1:0]    hist_wd;
   logic                 own_we;
   logic                 own_re;
   logic [CNT_W-1:0]     cnt_old, cnt_new;
   logic [HISTORY_K-1:0][STAMP_W-1:0] stamps_old, stamps_new;
   logic [STAMP_W-1:0]   stamp_next;
   logic [STAMP_W-1:0]   lruk_time;
   logic [STAMP_W-1:0]   own_time;
   logic [ADDR_W-1:0]    own_page;
   logic [FILL_W-1:0]    scan_prev;
   logic [31:0]          phys_wide;
   logic [31:0]          victim_wide;

   // Extract page number from the held address
   assign shifted = 32'(addr_ff) >> OFFSET_BITS;
   assign page_w  = ADDR_W'(shifted[PAGE_BITS-1:0]);

   // Advance the saturating stamp
   always_comb begin
      if (stamp_ff == '1) begin
         stamp_next = '0;
      end else if (stamp_ff < STAMP_MAX) begin
         stamp_next = stamp_ff + 32'd1;
      end else begin
         stamp_next = stamp_ff;
      end
   end

   // Shift the fresh stamp into the page history and derive its LRU-K time
   assign cnt_old    = hist_rd_ff[HIST_W-1 -: CNT_W];
   assign stamps_old = hist_rd_ff[STAMPS_W-1:0];
   always_comb begin
      stamps_new    = stamps_old;
      stamps_new[0] = stamp_next;
      for (int i = 1; i < HISTORY_K; i++) begin
         stamps_new[i] = stamps_old[i-1];
      end
      cnt_new = (cnt_old < CNT_W'(HISTORY_K)) ? cnt_old + CNT_W'(1) : cnt_old;
      lruk_time = (cnt_new < CNT_W'(HISTORY_K)) ? stamps_new[0] : stamps_new[HISTORY_K-1];
   end

   // Select write ports
   always_comb begin
      map_we  = cmd.clear_step | cmd.evict | cmd.commit;
      map_wa  = page_w;
      map_wd  = {1'b1, frame_ff};
      hist_we = cmd.clear_step | cmd.commit;
      hist_wa = page_w;
      hist_wd = {cnt_new, stamps_new};
      if (cmd.clear_step) begin
         map_wa  = clr_idx_ff;
         map_wd  = '0;
         hist_wa = clr_idx_ff;
         hist_wd = {{CNT_W{1'b0}}, {STAMPS_W{1'b1}}};
      end else if (cmd.evict) begin
         map_wa = best_page_ff;
         map_wd = '0;
      end
   end
   assign own_we = cmd.commit;
   assign own_re = cmd.scan_step && (scan_idx_ff < FILL_W'(FRAMES));

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_rd_ff <= map_mem[page_w];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[page_w];
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[frame_ff] <= {page_w, lruk_time};
      end
      if (own_re) begin
         own_rd_ff <= own_mem[scan_idx_ff[FRAME_W-1:0]];
      end
   end

   assign own_time  = own_rd_ff[STAMP_W-1:0];
   assign own_page  = own_rd_ff[OWN_W-1 -: ADDR_W];
   assign scan_prev = scan_idx_ff - FILL_W'(1);

   // Result formatting
   assign phys_wide   = (32'(frame_ff) << OFFSET_BITS) | 32'(addr_ff[OFFSET_BITS-1:0]);
   assign victim_wide = 32'(victim_ff);

   // Next-state logic for item, control, search and result registers
   always_comb begin
      addr_in        = addr_ff;
      frame_in       = frame_ff;
      outcome_in     = outcome_ff;
      victim_in      = victim_ff;
      clr_idx_in     = clr_idx_ff;
      fill_in        = fill_ff;
      scan_idx_in    = scan_idx_ff;
      stamp_in       = stamp_ff;
      best_frame_in  = best_frame_ff;
      best_time_in   = best_time_ff;
      best_page_in   = best_page_ff;
      rsp_phys_in    = rsp_phys_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;

      if (cmd.clear_step) begin
         clr_idx_in = clr_idx_ff + ADDR_W'(1);
      end
      if (cmd.capture) begin
         addr_in = req_logical_address;
      end
      // Hit keeps the mapped frame; a miss takes the next unfilled frame
      if (cmd.resolve) begin
         victim_in = '0;
         if (status.hit) begin
            frame_in   = map_rd_ff[FRAME_W-1:0];
            outcome_in = OUTCOME_HIT;
         end else begin
            frame_in   = fill_ff[FRAME_W-1:0];
            outcome_in = OUTCOME_FILL;
            if (status.has_free) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end
      // Keep the first frame with the strictly smallest time
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + FILL_W'(1);
         if (scan_idx_ff != '0) begin
            if ((scan_idx_ff == FILL_W'(1)) || (own_time < best_time_ff)) begin
               best_frame_in = scan_prev[FRAME_W-1:0];
               best_time_in  = own_time;
               best_page_in  = own_page;
            end
         end
      end
      if (cmd.evict) begin
         frame_in   = best_frame_ff;
         outcome_in = OUTCOME_EVICT;
         victim_in  = best_page_ff;
      end
      if (cmd.commit) begin
         stamp_in       = stamp_next;
         rsp_valid_in   = 1'b1;
         rsp_phys_in    = phys_wide[PHYS_W-1:0];
         rsp_outcome_in = outcome_ff;
         rsp_victim_in  = victim_wide[VICTIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         fill_ff      <= '0;
         scan_idx_ff  <= '0;
         stamp_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         fill_ff      <= fill_in;
         scan_idx_ff  <= scan_idx_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      frame_ff       <= frame_in;
      outcome_ff     <= outcome_in;
      victim_ff      <= victim_in;
      best_frame_ff  <= best_frame_in;
      best_time_ff   <= best_time_in;
      best_page_ff   <= best_page_in;
      rsp_phys_ff    <= rsp_phys_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_victim_ff  <= rsp_victim_in;
   end

   // Report status to the controller
   assign status.clear_last = (clr_idx_ff == ADDR_W'(PAGES - 1));
   assign status.hit        = map_rd_ff[MAP_W-1];
   assign status.has_free   = (fill_ff < FILL_W'(FRAMES));
   assign status.scan_done  = (scan_idx_ff == FILL_W'(FRAMES));
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_victim_page      = rsp_victim_ff;

   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(FRAMES), "fill count past frame count")
   `ASSERT_IMPLIES(a_evict_only_full, clock, reset, cmd.evict, !status.has_free, "eviction while a frame is free")
   `ASSERT_NEXT(a_victim_zero, clock, reset, cmd.commit && (outcome_ff != OUTCOME_EVICT), rsp_victim_page == '0, "victim page set without eviction")

endmodule

// ----- rtl/lru_k_page_translator.sv -----
// Sequencing: a hit or a fill of a free frame passes through the read, look and update
// states after the item is accepted; a miss with eviction also runs the victim scan,
// one frame a cycle over the frame table memory, and an evict state before update.
// A new item is taken only once the last one commits; commit waits for a free result slot.
// Reset: synchronous; a clearing pass then runs over the page tables,
// and no item is accepted until it ends.
module lru_k_page_translator
   import lkpt_pkg::*;
#(
   parameter int PAGES       = 64,
   parameter int FRAMES      = 16,
   parameter int OFFSET_BITS = 12,
   parameter int HISTORY_K   = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [LADDR_W-1:0]   req_logical_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PHYS_W-1:0]    rsp_physical_address,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [VICTIM_W-1:0]  rsp_victim_page
);

   cmd_type    cmd;
   status_type status;

   // Sequence each item
   lkpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold tables, stamps and the result register
   lkpt_dpath #(
      .PAGES       (PAGES),
      .FRAMES      (FRAMES),
      .OFFSET_BITS (OFFSET_BITS),
      .HISTORY_K   (HISTORY_K)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_logical_address  (req_logical_address),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_outcome          (rsp_outcome),
      .rsp_victim_page      (rsp_victim_page)
   );

endmodule
